@@ rtl/core/handheld_bus_memory_map_defines.svh @@
// Assertion macros used by the checker file of the memory map block.
`ifndef HANDHELD_BUS_MEMORY_MAP_DEFINES_SVH
`define HANDHELD_BUS_MEMORY_MAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HBMM_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HBMM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/hbmm_pkg.sv @@
// Types, codes, field widths and boot ROM contents of the memory map block.
package hbmm_pkg;

	localparam int ACTION_W    = 2;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 16;
	localparam int IO_IDX_W    = 7;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		UNIT_NONE  = 3'd0,
		UNIT_CART  = 3'd1,
		UNIT_SOUND = 3'd2,
		UNIT_LCD   = 3'd3,
		UNIT_TIMER = 3'd4
	} unit_t;

	typedef enum logic [2:0] {
		SRC_BYTE,
		SRC_VRAM,
		SRC_WRAM,
		SRC_OAM,
		SRC_HRAM,
		SRC_IO
	} src_t;

	// I/O bytes kept in flops rather than in the I/O RAM
	localparam logic [IO_IDX_W-1:0] IO_JOYP     = 7'h00;
	localparam logic [IO_IDX_W-1:0] IO_IF       = 7'h0F;
	localparam logic [IO_IDX_W-1:0] IO_BOOT_OFF = 7'h50;

	localparam logic [7:0] JOYP_RESET = 8'h0F;
	localparam logic [7:0] IF_JOYPAD  = 8'h10;
	localparam logic [7:0] BLOCKED_RD = 8'hFF;

	localparam logic [7:0] BOOT_ROM [256] = '{
		8'h31, 8'hfe, 8'hff, 8'haf, 8'h21, 8'hff, 8'h9f, 8'h32,
		8'hcb, 8'h7c, 8'h20, 8'hfb, 8'h21, 8'h26, 8'hff, 8'h0e,
		8'h11, 8'h3e, 8'h80, 8'h32, 8'he2, 8'h0c, 8'h3e, 8'hf3,
		8'he2, 8'h32, 8'h3e, 8'h77, 8'h77, 8'h3e, 8'hfc, 8'he0,
		8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1a,
		8'hcd, 8'h95, 8'h00, 8'hcd, 8'h96, 8'h00, 8'h13, 8'h7b,
		8'hfe, 8'h34, 8'h20, 8'hf3, 8'h11, 8'hd8, 8'h00, 8'h06,
		8'h08, 8'h1a, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hf9,
		8'h3e, 8'h19, 8'hea, 8'h10, 8'h99, 8'h21, 8'h2f, 8'h99,
		8'h0e, 8'h0c, 8'h3d, 8'h28, 8'h08, 8'h32, 8'h0d, 8'h20,
		8'hf9, 8'h2e, 8'h0f, 8'h18, 8'hf3, 8'h67, 8'h3e, 8'h64,
		8'h57, 8'he0, 8'h42, 8'h3e, 8'h91, 8'he0, 8'h40, 8'h04,
		8'h1e, 8'h02, 8'h0e, 8'h0c, 8'hf0, 8'h44, 8'hfe, 8'h90,
		8'h20, 8'hfa, 8'h0d, 8'h20, 8'hf7, 8'h1d, 8'h20, 8'hf2,
		8'h0e, 8'h13, 8'h24, 8'h7c, 8'h1e, 8'h83, 8'hfe, 8'h62,
		8'h28, 8'h06, 8'h1e, 8'hc1, 8'hfe, 8'h64, 8'h20, 8'h06,
		8'h7b, 8'he2, 8'h0c, 8'h3e, 8'h87, 8'he2, 8'hf0, 8'h42,
		8'h90, 8'he0, 8'h42, 8'h15, 8'h20, 8'hd2, 8'h05, 8'h20,
		8'h4f, 8'h16, 8'h20, 8'h18, 8'hcb, 8'h4f, 8'h06, 8'h04,
		8'hc5, 8'hcb, 8'h11, 8'h17, 8'hc1, 8'hcb, 8'h11, 8'h17,
		8'h05, 8'h20, 8'hf5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hc9,
		8'hce, 8'hed, 8'h66, 8'h66, 8'hcc, 8'h0d, 8'h00, 8'h0b,
		8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0c, 8'h00, 8'h0d,
		8'h00, 8'h08, 8'h11, 8'h1f, 8'h88, 8'h89, 8'h00, 8'h0e,
		8'hdc, 8'hcc, 8'h6e, 8'he6, 8'hdd, 8'hdd, 8'hd9, 8'h99,
		8'hbb, 8'hbb, 8'h67, 8'h63, 8'h6e, 8'h0e, 8'hec, 8'hcc,
		8'hdd, 8'hdc, 8'h99, 8'h9f, 8'hbb, 8'hb9, 8'h33, 8'h3e,
		8'h3c, 8'h42, 8'hb9, 8'ha5, 8'hb9, 8'ha5, 8'h42, 8'h3c,
		8'h21, 8'h04, 8'h01, 8'h11, 8'ha8, 8'h00, 8'h1a, 8'h13,
		8'hbe, 8'h20, 8'hfe, 8'h23, 8'h7d, 8'hfe, 8'h34, 8'h20,
		8'hf5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
		8'hfb, 8'h86, 8'h20, 8'hfe, 8'h3e, 8'h01, 8'he0, 8'h50
	};

	// Stage 1 payload: everything needed to form the result once RAM data is out
	typedef struct packed {
		src_t       src;
		logic [7:0] rd_byte;
		unit_t      unit;
		logic       irq;
		logic       io_vld;
	} stage_t;

	// External unit that owns an I/O byte
	function automatic unit_t io_unit(input logic [IO_IDX_W-1:0] idx);
		unit_t u;
		u = UNIT_NONE;
		if (idx >= 7'h10 && idx <= 7'h3F) begin
			u = UNIT_SOUND;
		end else if (idx >= 7'h40 && idx <= 7'h4B) begin
			u = UNIT_LCD;
		end else if (idx >= 7'h04 && idx <= 7'h07) begin
			u = UNIT_TIMER;
		end
		return u;
	endfunction

endpackage

@@ rtl/core/hbmm_ram.sv @@
// Single-port RAM with registered read data.
module hbmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ rtl/core/handheld_bus_memory_map.sv @@
// Handheld console memory map: takes one bus read, bus write or joypad scan tick per
// cycle while s_tready is high and returns one result transfer for each, through the
// stage 1 and output registers. Throughput is one item per cycle while m_tready keeps
// up; each item makes at most one access to one single-port RAM (video, work, sprite,
// high, I/O) with registered reads; the RAMs have no clearing pass, ready after reset.
module handheld_bus_memory_map #(
	parameter int VIDEO_RAM_BYTES = 8192,
	parameter int WORK_BANK_BYTES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// address[15:0], write_data[23:16], lcd_mode[25:24], lcd_enabled[26],
	// unit_read_data[34:27], key_states[42:35], zero fill above
	input  logic [hbmm_pkg::IN_TDATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [hbmm_pkg::ACTION_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_data[7:0], forward_unit[10:8], joypad_irq[11], zero fill above
	output logic [hbmm_pkg::OUT_TDATA_W-1:0] m_tdata
);

	import hbmm_pkg::*;

	localparam int VA_W = $clog2(VIDEO_RAM_BYTES);
	localparam int WB_W = $clog2(WORK_BANK_BYTES);

	action_t     action;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [1:0]  lcd_mode;
	logic        lcd_enabled;
	logic [7:0]  unit_read_data;
	logic [7:0]  key_states;

	assign action         = action_t'(s_tuser);
	assign address        = s_tdata[15:0];
	assign write_data     = s_tdata[23:16];
	assign lcd_mode       = s_tdata[25:24];
	assign lcd_enabled    = s_tdata[26];
	assign unit_read_data = s_tdata[34:27];
	assign key_states     = s_tdata[42:35];

	logic       accept;
	logic       valid_s1;
	stage_t     stg_s1;
	logic       out_valid_s2;
	logic [7:0] rd_s2;
	unit_t      unit_s2;
	logic       irq_s2;
	logic       out_free;

	logic [7:0] joyp_q;
	logic [7:0] if_q;
	logic [7:0] boot_off_q;
	logic [7:0] ie_q;
	logic [(1 << IO_IDX_W)-1:0] io_vld_q;

	assign out_free = !out_valid_s2 || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	// Decode
	logic r_vram, r_cart_hi, r_wram, r_oam, r_unused, r_io, r_hram;
	logic vram_blk, oam_blk;
	logic [IO_IDX_W-1:0] io_idx;
	logic vram_hit, vram_wr, wram_hit, wram_wr, oam_hit, oam_wr, hram_hit, hram_wr;
	logic io_hit, io_wr, ie_wr;
	logic [7:0] io_wdata;
	logic [7:0] joyp_d, if_d, boot_off_d;
	logic [7:0] joyp_tick;
	stage_t     stg_d;

	assign r_vram    = address[15:13] == 3'b100;
	assign r_cart_hi = address[15:13] == 3'b101;
	assign r_wram    = address[15:14] == 2'b11 && address < 16'hFE00;
	assign r_oam     = address >= 16'hFE00 && address <= 16'hFE9F;
	assign r_unused  = address >= 16'hFEA0 && address <= 16'hFEFF;
	assign r_io      = address >= 16'hFF00 && address <= 16'hFF7F;
	assign r_hram    = address >= 16'hFF80 && address <= 16'hFFFE;
	assign vram_blk  = lcd_enabled && lcd_mode == 2'd3;
	assign oam_blk   = lcd_enabled && lcd_mode[1];
	assign io_idx    = address[IO_IDX_W-1:0];

	always_comb begin
		joyp_tick = joyp_q | JOYP_RESET;
		case (joyp_tick[5:4])
			2'b10:   joyp_tick[3:0] = ~key_states[3:0];
			2'b01:   joyp_tick[3:0] = ~key_states[7:4];
			default: joyp_tick[3:0] = joyp_tick[3:0];
		endcase
	end

	always_comb begin
		vram_hit      = 1'b0;
		vram_wr       = 1'b0;
		wram_hit      = 1'b0;
		wram_wr       = 1'b0;
		oam_hit       = 1'b0;
		oam_wr        = 1'b0;
		hram_hit      = 1'b0;
		hram_wr       = 1'b0;
		io_hit        = 1'b0;
		io_wr         = 1'b0;
		io_wdata      = write_data;
		ie_wr         = 1'b0;
		joyp_d        = joyp_q;
		if_d          = if_q;
		boot_off_d    = boot_off_q;
		stg_d.src     = SRC_BYTE;
		stg_d.rd_byte = 8'h00;
		stg_d.unit    = UNIT_NONE;
		stg_d.irq     = 1'b0;
		stg_d.io_vld  = io_vld_q[io_idx];
		case (action)
			ACT_READ: begin
				if (!address[15]) begin
					if (address < 16'h0100 && boot_off_q == 8'h00) begin
						stg_d.rd_byte = BOOT_ROM[address[7:0]];
					end else begin
						stg_d.unit    = UNIT_CART;
						stg_d.rd_byte = unit_read_data;
					end
				end else if (r_vram) begin
					if (vram_blk) begin
						stg_d.rd_byte = BLOCKED_RD;
					end else begin
						vram_hit  = 1'b1;
						stg_d.src = SRC_VRAM;
					end
				end else if (r_cart_hi) begin
					stg_d.unit    = UNIT_CART;
					stg_d.rd_byte = unit_read_data;
				end else if (r_wram) begin
					wram_hit  = 1'b1;
					stg_d.src = SRC_WRAM;
				end else if (r_oam) begin
					if (oam_blk) begin
						stg_d.rd_byte = BLOCKED_RD;
					end else begin
						oam_hit   = 1'b1;
						stg_d.src = SRC_OAM;
					end
				end else if (r_unused) begin
					stg_d.rd_byte = 8'h00;
				end else if (r_io) begin
					stg_d.unit = io_unit(io_idx);
					if (stg_d.unit != UNIT_NONE) begin
						// latch the unit's byte into I/O and pass it through
						io_hit        = 1'b1;
						io_wr         = 1'b1;
						io_wdata      = unit_read_data;
						stg_d.rd_byte = unit_read_data;
					end else if (io_idx == IO_JOYP) begin
						stg_d.rd_byte = joyp_q;
					end else if (io_idx == IO_IF) begin
						stg_d.rd_byte = if_q;
					end else if (io_idx == IO_BOOT_OFF) begin
						stg_d.rd_byte = boot_off_q;
					end else begin
						io_hit    = 1'b1;
						stg_d.src = SRC_IO;
					end
				end else if (r_hram) begin
					hram_hit  = 1'b1;
					stg_d.src = SRC_HRAM;
				end else begin
					stg_d.rd_byte = ie_q;
				end
			end
			ACT_WRITE: begin
				if (!address[15] || r_cart_hi) begin
					stg_d.unit = UNIT_CART;
				end else if (r_vram) begin
					vram_hit = !vram_blk;
					vram_wr  = !vram_blk;
				end else if (r_wram) begin
					wram_hit = 1'b1;
					wram_wr  = 1'b1;
				end else if (r_oam) begin
					oam_hit = !oam_blk;
					oam_wr  = !oam_blk;
				end else if (r_io) begin
					stg_d.unit = io_unit(io_idx);
					if (io_idx == IO_JOYP) begin
						joyp_d = {write_data[7:4], 4'h0};
					end else if (io_idx == IO_IF) begin
						if_d = write_data;
					end else if (io_idx == IO_BOOT_OFF) begin
						boot_off_d = write_data;
					end else begin
						io_hit = 1'b1;
						io_wr  = 1'b1;
					end
				end else if (r_hram) begin
					hram_hit = 1'b1;
					hram_wr  = 1'b1;
				end else if (!r_unused) begin
					ie_wr = 1'b1;
				end
			end
			ACT_TICK: begin
				joyp_d    = joyp_tick;
				stg_d.irq = joyp_tick[3:0] != 4'hF;
				if (stg_d.irq) begin
					if_d = if_q | IF_JOYPAD;
				end
			end
			default: begin
			end
		endcase
	end

	// Memories
	logic [7:0] vram_rd, wram_rd, oam_rd, hram_rd, io_rd;

	hbmm_ram #(.WIDTH(8), .DEPTH(VIDEO_RAM_BYTES)) u_vram (
		.clk   (clk),
		.en    (accept && vram_hit),
		.we    (vram_wr),
		.addr  (address[VA_W-1:0]),
		.wdata (write_data),
		.rdata (vram_rd)
	);

	// both banks in one array; address bit 12 picks the bank, echo included
	hbmm_ram #(.WIDTH(8), .DEPTH(2 * WORK_BANK_BYTES)) u_wram (
		.clk   (clk),
		.en    (accept && wram_hit),
		.we    (wram_wr),
		.addr  ({address[WB_W], address[WB_W-1:0]}),
		.wdata (write_data),
		.rdata (wram_rd)
	);

	hbmm_ram #(.WIDTH(8), .DEPTH(160)) u_oam (
		.clk   (clk),
		.en    (accept && oam_hit),
		.we    (oam_wr),
		.addr  (address[7:0]),
		.wdata (write_data),
		.rdata (oam_rd)
	);

	hbmm_ram #(.WIDTH(8), .DEPTH(127)) u_hram (
		.clk   (clk),
		.en    (accept && hram_hit),
		.we    (hram_wr),
		.addr  (address[6:0]),
		.wdata (write_data),
		.rdata (hram_rd)
	);

	hbmm_ram #(.WIDTH(8), .DEPTH(1 << IO_IDX_W)) u_io (
		.clk   (clk),
		.en    (accept && io_hit),
		.we    (io_wr),
		.addr  (io_idx),
		.wdata (io_wdata),
		.rdata (io_rd)
	);

	// I/O flops with reset values; unwritten I/O RAM bytes read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joyp_q     <= JOYP_RESET;
			if_q       <= 8'h00;
			boot_off_q <= 8'h00;
			io_vld_q   <= '0;
		end else if (accept) begin
			joyp_q     <= joyp_d;
			if_q       <= if_d;
			boot_off_q <= boot_off_d;
			if (io_hit && io_wr) begin
				io_vld_q[io_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ie_wr) begin
			ie_q <= write_data;
		end
	end

	// Stage 1 and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_s2 <= valid_s1;
			end
		end
	end

	logic [7:0] rd_sel;

	always_comb begin
		case (stg_s1.src)
			SRC_VRAM: rd_sel = vram_rd;
			SRC_WRAM: rd_sel = wram_rd;
			SRC_OAM:  rd_sel = oam_rd;
			SRC_HRAM: rd_sel = hram_rd;
			SRC_IO:   rd_sel = stg_s1.io_vld ? io_rd : 8'h00;
			default:  rd_sel = stg_s1.rd_byte;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stg_s1 <= stg_d;
		end
		if (out_free && valid_s1) begin
			rd_s2   <= rd_sel;
			unit_s2 <= stg_s1.unit;
			irq_s2  <= stg_s1.irq;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {4'b0000, irq_s2, unit_s2, rd_s2};

endmodule

@@ rtl/core/hbmm_checker.sv @@
// Port-level checks on the result stream of the memory map block, bound to the top level.
`include "handheld_bus_memory_map_defines.svh"

module hbmm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [hbmm_pkg::OUT_TDATA_W-1:0] m_tdata
);

	import hbmm_pkg::*;

	// hold a stalled result
	`HBMM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// a scan tick result carries no read byte and no forwarding
	`HBMM_ASSERT_IMPLY(a_irq_alone, m_tvalid && m_tdata[11], m_tdata[10:0] == 11'd0, "joypad irq with data or unit")

	`HBMM_ASSERT_IMPLY(a_unit_code, m_tvalid, m_tdata[10:8] <= UNIT_TIMER, "forward unit code out of range")

	`HBMM_ASSERT_IMPLY(a_pad_zero, m_tvalid, m_tdata[15:12] == 4'h0, "result fill bits not zero")

endmodule

bind handheld_bus_memory_map hbmm_checker u_hbmm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
